// ===== sv/cctwc_pkg.sv =====
// Shared types, class codes and byte helpers of the tokenizer and word counter.
package cctwc_pkg;

    // Token class codes; the low two bits are the reported class.
    localparam logic [2:0] CLS_WORD  = 3'd0;
    localparam logic [2:0] CLS_NUM   = 3'd1;
    localparam logic [2:0] CLS_PUNCT = 3'd2;
    localparam logic [2:0] CLS_SPACE = 3'd3;
    localparam logic [2:0] CLS_NONE  = 3'd4;

    // Write and read enables of the word table.
    typedef struct packed {
        logic rd;
        logic wr_word;
        logic wr_freq;
    } tbl_ctl_t;

    // Class one raw byte.
    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] c;
        c = CLS_NONE;
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
            b == 8'hC3 || b == 8'hA9) begin
            c = CLS_WORD;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = CLS_NUM;
        end else begin
            case (b)
                8'h2C, 8'h2E, 8'h2F, 8'h3B, 8'h27, 8'h5B, 8'h5D, 8'h3A,
                8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h3F, 8'h7E, 8'h21, 8'h40,
                8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
                8'h5F, 8'h2B, 8'h2D, 8'h3D, 8'h7C, 8'h22:
                    c = CLS_PUNCT;
                8'h20, 8'h09, 8'h0A, 8'h0D:
                    c = CLS_SPACE;
                default:
                    c = CLS_NONE;
            endcase
        end
        return c;
    endfunction

    // Fold A-Z to lower case, leave every other byte alone.
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    // Increment with saturation at all ones.
    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        logic [31:0] r;
        r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        return r;
    endfunction

endpackage

// ===== sv/char_class_tokenizer_word_counter_core.sv =====
// Top level: byte classing, run tracking, word table walk and result register.
//
//  channel | direction | handshake          | payload
//  in      | to core   | in_valid, in_stall | text_byte, end_of_text
//  out     | from core | out_valid,out_stall| token class, length, word and totals
//
//  A byte that closes no run passes through accept, decide and apply; each result
//  adds the close and emit steps plus any wait for the output register.
//  A word close also walks the table over a single read port, with a read and
//  a compare step per stored entry, plus a miss step when no entry matches.
//  Reset clears control state and totals; table memories are not cleared,
//  only entries below the fill count are read.
//  in_stall is high whenever an item is in progress; out_stall holds the
//  result register and blocks the next result.
module char_class_tokenizer_word_counter_core
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int MAX_WORD_LEN = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  token_class,
    output logic [15:0] token_length,
    output logic [9:0]  word_index,
    output logic [31:0] word_count,
    output logic        new_word,
    output logic        table_full,
    output logic        word_truncated,
    output logic        last_result,
    output logic [31:0] total_words,
    output logic [31:0] total_digit_chars,
    output logic [31:0] total_punct_chars,
    output logic [31:0] total_space_chars
);
    import cctwc_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int RW = MAX_WORD_LEN * 8;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_APPLY, S_CLOSE, S_RD, S_CMP, S_MISS, S_EMIT
    } state_t;

    state_t      state_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;
    logic [2:0]  cls_reg;
    logic        second_reg;
    logic [2:0]  run_class_reg;
    logic [15:0] run_length_reg;
    logic [LW-1:0] wlen_reg;
    logic        trunc_reg;
    logic [IW-1:0] idx_reg;
    logic [EW-1:0] entries_reg;
    logic [31:0] cnt_reg;
    logic        fresh_reg;
    logic        full_reg;
    logic [31:0] tot_word_reg;
    logic [31:0] tot_digit_reg;
    logic [31:0] tot_punct_reg;
    logic [31:0] tot_space_reg;

    logic        out_valid_reg;
    logic [1:0]  o_class_reg;
    logic [15:0] o_length_reg;
    logic [9:0]  o_index_reg;
    logic [31:0] o_count_reg;
    logic        o_new_reg;
    logic        o_full_reg;
    logic        o_trunc_reg;
    logic        o_last_reg;
    logic [31:0] o_words_reg;
    logic [31:0] o_digits_reg;
    logic [31:0] o_puncts_reg;
    logic [31:0] o_spaces_reg;

    // Word chain and table signals
    logic [7:0]    chain_byte [0:MAX_WORD_LEN];
    logic          chain_match [0:MAX_WORD_LEN];
    logic [RW-1:0] cur_row;
    logic [RW-1:0] rd_row;
    logic [LW-1:0] rd_len;
    logic [31:0]   rd_freq;
    logic          shift_en;
    tbl_ctl_t      tctl;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_freq;
    logic          hit;
    logic [31:0]   freq_inc;
    logic          out_free;
    logic [31:0]   tot_word_next;
    logic [31:0]   idx_wide;

    assign shift_en = (state_reg == S_APPLY) && (cls_reg == CLS_WORD) &&
                      (run_length_reg < 16'(MAX_WORD_LEN));
    assign chain_byte[0]  = to_lower(byte_reg);
    assign chain_match[0] = 1'b1;

    // Build the row of cells; cell 0 holds the latest letter.
    genvar k;
    generate
        for (k = 0; k < MAX_WORD_LEN; k++)
        begin : g_cell
            cctwc_cell u_cell
            (
                .clk       (clk),
                .shift_en  (shift_en),
                .din       (chain_byte[k]),
                .dout      (chain_byte[k+1]),
                .row_byte  (rd_row[k*8 +: 8]),
                .care      (LW'(k) < wlen_reg),
                .match_in  (chain_match[k]),
                .match_out (chain_match[k+1])
            );
            assign cur_row[k*8 +: 8] = chain_byte[k+1];
        end
    endgenerate

    assign hit      = chain_match[MAX_WORD_LEN] && (rd_len == wlen_reg);
    assign freq_inc = sat_inc32(rd_freq);
    assign out_free = !out_valid_reg || !out_stall;
    assign tot_word_next = (run_class_reg == CLS_WORD) ? sat_inc32(tot_word_reg)
                                                       : tot_word_reg;
    assign idx_wide = 32'(idx_reg);

    // Drive table enables from the walk state.
    always_comb
    begin
        tctl    = '0;
        wr_addr = idx_reg;
        wr_freq = freq_inc;
        unique case (state_reg)
            S_RD:
                tctl.rd = 1'b1;
            S_CMP:
                tctl.wr_freq = hit;
            S_MISS:
            begin
                tctl.wr_word = (entries_reg < EW'(TABLE_DEPTH));
                tctl.wr_freq = (entries_reg < EW'(TABLE_DEPTH));
                wr_addr      = IW'(entries_reg);
                wr_freq      = 32'd1;
            end
            default:
                tctl = '0;
        endcase
    end

    cctwc_table
    #(
        .DEPTH (TABLE_DEPTH),
        .WLEN  (MAX_WORD_LEN),
        .IW    (IW),
        .LW    (LW)
    )
    u_table
    (
        .clk     (clk),
        .ctl     (tctl),
        .rd_addr (idx_reg),
        .wr_addr (wr_addr),
        .wr_row  (cur_row),
        .wr_len  (wlen_reg),
        .wr_freq (wr_freq),
        .rd_row  (rd_row),
        .rd_len  (rd_len),
        .rd_freq (rd_freq)
    );

    // One byte: close a changed run, apply, close at end of text, hold the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            byte_reg       <= '0;
            eot_reg        <= 1'b0;
            cls_reg        <= CLS_NONE;
            second_reg     <= 1'b0;
            run_class_reg  <= CLS_NONE;
            run_length_reg <= '0;
            wlen_reg       <= '0;
            trunc_reg      <= 1'b0;
            idx_reg        <= '0;
            entries_reg    <= '0;
            cnt_reg        <= '0;
            fresh_reg      <= 1'b0;
            full_reg       <= 1'b0;
            tot_word_reg   <= '0;
            tot_digit_reg  <= '0;
            tot_punct_reg  <= '0;
            tot_space_reg  <= '0;
            out_valid_reg  <= 1'b0;
            o_class_reg    <= '0;
            o_length_reg   <= '0;
            o_index_reg    <= '0;
            o_count_reg    <= '0;
            o_new_reg      <= 1'b0;
            o_full_reg     <= 1'b0;
            o_trunc_reg    <= 1'b0;
            o_last_reg     <= 1'b0;
            o_words_reg    <= '0;
            o_digits_reg   <= '0;
            o_puncts_reg   <= '0;
            o_spaces_reg   <= '0;
        end
        else
        begin
            // Drop the result once it is taken.
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        byte_reg  <= text_byte;
                        eot_reg   <= end_of_text;
                        cls_reg   <= classify(text_byte);
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (run_class_reg != CLS_NONE && cls_reg != run_class_reg)
                    begin
                        second_reg <= 1'b0;
                        state_reg  <= S_CLOSE;
                    end
                    else
                    begin
                        state_reg <= S_APPLY;
                    end
                end

                S_APPLY:
                begin
                    if (cls_reg != CLS_NONE)
                    begin
                        run_class_reg <= cls_reg;
                        if (run_length_reg != 16'hFFFF)
                        begin
                            run_length_reg <= run_length_reg + 16'd1;
                        end
                        if (cls_reg == CLS_NUM)
                        begin
                            tot_digit_reg <= sat_inc32(tot_digit_reg);
                        end
                        if (cls_reg == CLS_PUNCT)
                        begin
                            tot_punct_reg <= sat_inc32(tot_punct_reg);
                        end
                        if (cls_reg == CLS_SPACE)
                        begin
                            tot_space_reg <= sat_inc32(tot_space_reg);
                        end
                    end
                    if (eot_reg && cls_reg != CLS_NONE)
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_CLOSE;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_CLOSE:
                begin
                    idx_reg   <= '0;
                    cnt_reg   <= '0;
                    fresh_reg <= 1'b0;
                    full_reg  <= 1'b0;
                    trunc_reg <= run_length_reg > 16'(MAX_WORD_LEN);
                    wlen_reg  <= (run_length_reg < 16'(MAX_WORD_LEN)) ?
                                 LW'(run_length_reg) : LW'(MAX_WORD_LEN);
                    if (run_class_reg != CLS_WORD)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (entries_reg == '0)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end

                S_RD:
                begin
                    state_reg <= S_CMP;
                end

                S_CMP:
                begin
                    if (hit)
                    begin
                        cnt_reg   <= freq_inc;
                        state_reg <= S_EMIT;
                    end
                    else if (EW'(idx_reg) + EW'(1) == entries_reg)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_RD;
                    end
                end

                S_MISS:
                begin
                    if (entries_reg < EW'(TABLE_DEPTH))
                    begin
                        idx_reg     <= IW'(entries_reg);
                        cnt_reg     <= 32'd1;
                        fresh_reg   <= 1'b1;
                        entries_reg <= entries_reg + EW'(1);
                    end
                    else
                    begin
                        idx_reg  <= '0;
                        full_reg <= 1'b1;
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        o_class_reg    <= run_class_reg[1:0];
                        o_length_reg   <= run_length_reg;
                        o_index_reg    <= idx_wide[9:0];
                        o_count_reg    <= cnt_reg;
                        o_new_reg      <= fresh_reg;
                        o_full_reg     <= full_reg;
                        o_trunc_reg    <= (run_class_reg == CLS_WORD) && trunc_reg;
                        o_last_reg     <= second_reg || !(eot_reg && cls_reg != CLS_NONE);
                        o_words_reg    <= tot_word_next;
                        o_digits_reg   <= tot_digit_reg;
                        o_puncts_reg   <= tot_punct_reg;
                        o_spaces_reg   <= tot_space_reg;
                        tot_word_reg   <= tot_word_next;
                        run_class_reg  <= CLS_NONE;
                        run_length_reg <= '0;
                        state_reg      <= second_reg ? S_IDLE : S_APPLY;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign token_class       = o_class_reg;
    assign token_length      = o_length_reg;
    assign word_index        = o_index_reg;
    assign word_count        = o_count_reg;
    assign new_word          = o_new_reg;
    assign table_full        = o_full_reg;
    assign word_truncated    = o_trunc_reg;
    assign last_result       = o_last_reg;
    assign total_words       = o_words_reg;
    assign total_digit_chars = o_digits_reg;
    assign total_punct_chars = o_puncts_reg;
    assign total_space_chars = o_spaces_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg <= EW'(TABLE_DEPTH))
        else $error("fill count past table depth");

    a_new_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(o_new_reg && o_full_reg))
        else $error("word both inserted and rejected");

    a_nonword_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_class_reg != CLS_WORD[1:0] |->
            o_count_reg == '0 && !o_new_reg && !o_trunc_reg)
        else $error("word fields set on a non-word token");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("core took a byte without going busy");
`endif

endmodule

// ===== sv/cctwc_cell.sv =====
// One cell of the word chain: holds a byte, shifts it on, and compares it.
module cctwc_cell
(
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] din,
    output logic [7:0] dout,
    input  logic [7:0] row_byte,
    input  logic       care,
    input  logic       match_in,
    output logic       match_out
);
    logic [7:0] byte_reg;

    // Take the neighbor's byte when the chain advances.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

    // Pass the match on, ignoring cells past the word's end.
    assign match_out = match_in & (~care | (byte_reg == row_byte));

endmodule

// ===== sv/cctwc_table.sv =====
// Word table storage: stored words, their lengths and their counts.
module cctwc_table
#(
    parameter int DEPTH = 1024,
    parameter int WLEN  = 32,
    parameter int IW    = 10,
    parameter int LW    = 6
)
(
    input  logic                      clk,
    input  cctwc_pkg::tbl_ctl_t       ctl,
    input  logic [IW-1:0]             rd_addr,
    input  logic [IW-1:0]             wr_addr,
    input  logic [WLEN*8-1:0]         wr_row,
    input  logic [LW-1:0]             wr_len,
    input  logic [31:0]               wr_freq,
    output logic [WLEN*8-1:0]         rd_row,
    output logic [LW-1:0]             rd_len,
    output logic [31:0]               rd_freq
);
    logic [WLEN*8-1:0] row_mem  [0:DEPTH-1];
    logic [LW-1:0]     len_mem  [0:DEPTH-1];
    logic [31:0]       freq_mem [0:DEPTH-1];

    // Write a new word and its count, or an updated count alone.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_word)
        begin
            row_mem[wr_addr] <= wr_row;
            len_mem[wr_addr] <= wr_len;
        end
        if (ctl.wr_freq)
        begin
            freq_mem[wr_addr] <= wr_freq;
        end
    end

    // Read one entry into the output registers.
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_row  <= row_mem[rd_addr];
            rd_len  <= len_mem[rd_addr];
            rd_freq <= freq_mem[rd_addr];
        end
    end

endmodule
